[rtl/core/assert_macros.svh]
// Assertion macros for the row zero elimination RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RZE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rze assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define RZE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("rze assertion failed");

`endif

[rtl/core/rze_pkg.sv]
// Package: constants and types of the row zero elimination unit
`default_nettype none
package rze_pkg;

  // Row geometry
  localparam int LANES          = 8;
  localparam int SHIFT_W        = $clog2(LANES);
  localparam int CNT_W          = $clog2(LANES) + 1;
  localparam int NUM_SHIFT_STG  = $clog2(LANES);
  localparam int ELEM_WIDTH_DEF = 16;

  // Configuration port
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;
  localparam int ROW_LEN_W      = 4;
  localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = ROW_LEN_W'(LANES);

  // Register indexes
  localparam logic REG_ROW_LENGTH = 1'b0;

  // Control fields that travel with a row through the pipeline
  typedef struct packed {
    logic             last;
    logic [CNT_W-1:0] count;
  } rze_ctrl_t;

endpackage
`default_nettype wire

[rtl/core/rze_row_if.sv]
// Interface: input row channel (eight lanes plus last-row flag)
`default_nettype none
interface rze_row_if #(
  parameter int ELEM_WIDTH = rze_pkg::ELEM_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [ELEM_WIDTH-1:0] lane_0;
  logic [ELEM_WIDTH-1:0] lane_1;
  logic [ELEM_WIDTH-1:0] lane_2;
  logic [ELEM_WIDTH-1:0] lane_3;
  logic [ELEM_WIDTH-1:0] lane_4;
  logic [ELEM_WIDTH-1:0] lane_5;
  logic [ELEM_WIDTH-1:0] lane_6;
  logic [ELEM_WIDTH-1:0] lane_7;
  logic                  row_last;

  modport source (
    output valid, lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6, lane_7,
           row_last,
    input  ready
  );
  modport sink (
    input  valid, lane_0, lane_1, lane_2, lane_3, lane_4, lane_5, lane_6, lane_7,
           row_last,
    output ready
  );
endinterface
`default_nettype wire

[rtl/core/rze_pack_if.sv]
// Interface: packed result channel (compacted lanes, count, last-row flag)
`default_nettype none
interface rze_pack_if #(
  parameter int ELEM_WIDTH = rze_pkg::ELEM_WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic [ELEM_WIDTH-1:0]      packed_0;
  logic [ELEM_WIDTH-1:0]      packed_1;
  logic [ELEM_WIDTH-1:0]      packed_2;
  logic [ELEM_WIDTH-1:0]      packed_3;
  logic [ELEM_WIDTH-1:0]      packed_4;
  logic [ELEM_WIDTH-1:0]      packed_5;
  logic [ELEM_WIDTH-1:0]      packed_6;
  logic [ELEM_WIDTH-1:0]      packed_7;
  logic [rze_pkg::CNT_W-1:0]  nonzero_count;
  logic                       last_row_out;

  modport source (
    output valid, packed_0, packed_1, packed_2, packed_3, packed_4, packed_5,
           packed_6, packed_7, nonzero_count, last_row_out,
    input  ready
  );
  modport sink (
    input  valid, packed_0, packed_1, packed_2, packed_3, packed_4, packed_5,
           packed_6, packed_7, nonzero_count, last_row_out,
    output ready
  );
endinterface
`default_nettype wire

[rtl/core/rze_shift_stage.sv]
// One registered stage of the log shifter: moves tagged elements down by 2^BIT
`default_nettype none
module rze_shift_stage #(
  parameter int ELEM_WIDTH = rze_pkg::ELEM_WIDTH_DEF,
  parameter int BIT        = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          vld_i,
  input  wire logic [ELEM_WIDTH-1:0]         lane_i  [rze_pkg::LANES],
  input  wire logic [rze_pkg::SHIFT_W-1:0]   shift_i [rze_pkg::LANES],
  input  wire rze_pkg::rze_ctrl_t            ctrl_i,
  output logic                               vld_o,
  output logic [ELEM_WIDTH-1:0]              lane_o  [rze_pkg::LANES],
  output logic [rze_pkg::SHIFT_W-1:0]        shift_o [rze_pkg::LANES],
  output rze_pkg::rze_ctrl_t                 ctrl_o
);
  import rze_pkg::*;

  localparam int DIST = 1 << BIT;

  logic                  mov     [LANES];
  logic [ELEM_WIDTH-1:0] lane_d  [LANES];
  logic [SHIFT_W-1:0]    shift_d [LANES];
  logic [ELEM_WIDTH-1:0] lane_q  [LANES];
  logic [SHIFT_W-1:0]    shift_q [LANES];
  rze_ctrl_t             ctrl_q;
  logic                  vld_q;

  // An element moves when it is nonzero and its count has this bit set
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      mov[i] = (i >= DIST) && (lane_i[i] != '0) && shift_i[i][BIT];
    end
  end

  // Arriving element wins; a lane that sends its element away is cleared
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      lane_d[j]  = lane_i[j];
      shift_d[j] = shift_i[j];
      if ((j + DIST < LANES) && mov[(j + DIST) % LANES]) begin
        lane_d[j]  = lane_i[(j + DIST) % LANES];
        shift_d[j] = shift_i[(j + DIST) % LANES];
      end else if (mov[j]) begin
        lane_d[j]  = '0;
        shift_d[j] = '0;
      end
    end
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (en_i && vld_i) begin
      lane_q  <= lane_d;
      shift_q <= shift_d;
      ctrl_q  <= ctrl_i;
    end
  end

  assign vld_o   = vld_q;
  assign lane_o  = lane_q;
  assign shift_o = shift_q;
  assign ctrl_o  = ctrl_q;

endmodule
`default_nettype wire

[rtl/core/row_zero_elimination_unit.sv]
// Top level: row zero elimination (prefix zero count and log shifter)
//
//  channel   | role    | payload
//  ----------+---------+----------------------------------------------------
//  rows_i    | sink    | lane_0..lane_7 (ELEM_WIDTH), row_last
//  packed_o  | source  | packed_0..packed_7, nonzero_count (4), last_row_out
//  APB       | slave   | row_length at byte address 0, pready always high
//
// One row per cycle while the output is not stalled; a row passes one registered
// stage for lane masking and the prefix zero count, then one stage per shifter bit.
// Reset clears all stage valid bits and sets row_length to 8.
// Each stage takes a new row when it is empty or its successor advances, so a
// stalled output only backs up full stages and bubbles are squeezed out.
`default_nettype none
`include "assert_macros.svh"
module row_zero_elimination_unit #(
  parameter int ELEM_WIDTH = rze_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  rze_row_if.sink                                rows_i,
  rze_pack_if.source                             packed_o,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [rze_pkg::APB_ADDR_W-1:0]    paddr,
  input  wire logic [rze_pkg::APB_DATA_W-1:0]    pwdata,
  output logic      [rze_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                   pready
);
  import rze_pkg::*;

  localparam int NS = NUM_SHIFT_STG;

  // Configuration register
  logic [ROW_LEN_W-1:0] row_length_q, row_length_d;
  logic                 reg_sel;

  // Stage 0 signals
  logic [ELEM_WIDTH-1:0] in_lane     [LANES];
  logic [ELEM_WIDTH-1:0] s0_lane_d   [LANES];
  logic [SHIFT_W-1:0]    s0_shift_d  [LANES];
  rze_ctrl_t             s0_ctrl_d;
  logic [ELEM_WIDTH-1:0] s0_lane_q   [LANES];
  logic [SHIFT_W-1:0]    s0_shift_q  [LANES];
  rze_ctrl_t             s0_ctrl_q;
  logic                  s0_vld_q;

  // Pipeline view: index 0 is stage 0, index k is shifter stage k
  logic                  pl_vld   [NS+1];
  logic                  pl_en    [NS+1];
  logic [ELEM_WIDTH-1:0] pl_lane  [NS+1][LANES];
  logic [SHIFT_W-1:0]    pl_shift [NS+1][LANES];
  rze_ctrl_t             pl_ctrl  [NS+1];

  logic                  src_ok;

  // APB register access
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_ROW_LENGTH);

  always_comb begin
    row_length_d = row_length_q;
    if (psel && penable && pwrite && reg_sel) begin
      row_length_d = pwdata[ROW_LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q <= ROW_LEN_RESET;
    end else begin
      row_length_q <= row_length_d;
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(row_length_q) : '0;

  // Input lanes as an array
  assign in_lane[0] = rows_i.lane_0;
  assign in_lane[1] = rows_i.lane_1;
  assign in_lane[2] = rows_i.lane_2;
  assign in_lane[3] = rows_i.lane_3;
  assign in_lane[4] = rows_i.lane_4;
  assign in_lane[5] = rows_i.lane_5;
  assign in_lane[6] = rows_i.lane_6;
  assign in_lane[7] = rows_i.lane_7;

  // Stage 0: mask unused lanes, prefix zero count, nonzero count
  always_comb begin
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] zacc;
    logic             inuse;
    used = (CNT_W'(row_length_q) > CNT_W'(LANES)) ? CNT_W'(LANES) : CNT_W'(row_length_q);
    zacc = '0;
    for (int i = 0; i < LANES; i++) begin
      inuse         = (CNT_W'(i) < used);
      s0_lane_d[i]  = inuse ? in_lane[i] : '0;
      s0_shift_d[i] = zacc[SHIFT_W-1:0];
      if (inuse && (in_lane[i] == '0)) begin
        zacc = zacc + 1'b1;
      end
    end
    s0_ctrl_d.count = used - zacc;
    s0_ctrl_d.last  = rows_i.row_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (pl_en[0]) begin
      s0_vld_q <= rows_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pl_en[0] && rows_i.valid) begin
      s0_lane_q  <= s0_lane_d;
      s0_shift_q <= s0_shift_d;
      s0_ctrl_q  <= s0_ctrl_d;
    end
  end

  assign pl_vld[0]   = s0_vld_q;
  assign pl_lane[0]  = s0_lane_q;
  assign pl_shift[0] = s0_shift_q;
  assign pl_ctrl[0]  = s0_ctrl_q;

  // Stage enables: a stage loads when empty or when its successor loads
  always_comb begin
    pl_en[NS] = !pl_vld[NS] || packed_o.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      pl_en[k] = !pl_vld[k] || pl_en[k+1];
    end
  end

  assign rows_i.ready = pl_en[0];

  // Log shifter, one registered stage per count bit
  for (genvar k = 1; k <= NS; k++) begin : g_shift
    rze_shift_stage #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .BIT        (k - 1)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pl_en[k]),
      .vld_i   (pl_vld[k-1]),
      .lane_i  (pl_lane[k-1]),
      .shift_i (pl_shift[k-1]),
      .ctrl_i  (pl_ctrl[k-1]),
      .vld_o   (pl_vld[k]),
      .lane_o  (pl_lane[k]),
      .shift_o (pl_shift[k]),
      .ctrl_o  (pl_ctrl[k])
    );
  end

  // Result transaction
  assign packed_o.valid         = pl_vld[NS];
  assign packed_o.packed_0      = pl_lane[NS][0];
  assign packed_o.packed_1      = pl_lane[NS][1];
  assign packed_o.packed_2      = pl_lane[NS][2];
  assign packed_o.packed_3      = pl_lane[NS][3];
  assign packed_o.packed_4      = pl_lane[NS][4];
  assign packed_o.packed_5      = pl_lane[NS][5];
  assign packed_o.packed_6      = pl_lane[NS][6];
  assign packed_o.packed_7      = pl_lane[NS][7];
  assign packed_o.nonzero_count = pl_ctrl[NS].count;
  assign packed_o.last_row_out  = pl_ctrl[NS].last;

  // Every surviving element's carried count points back to a real lane
  always_comb begin
    src_ok = 1'b1;
    for (int j = 0; j < LANES; j++) begin
      if ((pl_lane[NS][j] != '0) &&
          ((CNT_W'(j) + CNT_W'(pl_shift[NS][j])) >= CNT_W'(LANES))) begin
        src_ok = 1'b0;
      end
    end
  end

  // Checks
  `RZE_ASSERT_IMPLY(a_ready_only_when_full, clk_i, rst_ni,
    !rows_i.ready, s0_vld_q)
  `RZE_ASSERT_NEXT(a_stalled_stage_holds, clk_i, rst_ni,
    pl_vld[1] && !pl_en[1], pl_vld[1])
  `RZE_ASSERT_IMPLY(a_empty_row_is_zero, clk_i, rst_ni,
    packed_o.valid && (packed_o.nonzero_count == '0), packed_o.packed_0 == '0)
  `RZE_ASSERT_IMPLY(a_top_lane_clear, clk_i, rst_ni,
    packed_o.valid && (packed_o.nonzero_count < CNT_W'(LANES)), packed_o.packed_7 == '0)
  `RZE_ASSERT_IMPLY(a_count_source_ok, clk_i, rst_ni,
    packed_o.valid, src_ok)

endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for the row zero elimination unit
`timescale 1ns / 100ps

module testbench;
  import rze_pkg::*;

  localparam int ELEM_W       = ELEM_WIDTH_DEF;
  localparam int PIPE_LATENCY = 4;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;
  localparam int RANDOM_PHASES = 18;

  // Byte addresses: row_length and the first index past the register map
  localparam logic [APB_ADDR_W-1:0] ADDR_ROW_LENGTH = APB_ADDR_W'(REG_ROW_LENGTH) << 2;
  localparam int UNMAPPED_REG_IDX = 1;
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = APB_ADDR_W'(UNMAPPED_REG_IDX) << 2;

  typedef logic signed [ELEM_W-1:0] elem_t;

  // One input row and one compacted row
  typedef struct packed {
    logic                    last;
    elem_t [LANES-1:0]       lanes;
  } row_t;

  typedef struct packed {
    elem_t [LANES-1:0]       slots;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } compaction_t;

  // Receiver pacing modes
  typedef enum int unsigned {
    PACE_FREE,
    PACE_RANDOM,
    PACE_PATTERN
  } pace_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  rze_row_if  #(.ELEM_WIDTH(ELEM_W)) row_ch  ();
  rze_pack_if #(.ELEM_WIDTH(ELEM_W)) pack_ch ();

  row_zero_elimination_unit #(.ELEM_WIDTH(ELEM_W)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rows_i   (row_ch),
    .packed_o (pack_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow of row_length and rows in flight
  logic [ROW_LEN_W-1:0] cur_row_len;
  compaction_t          pending_compactions[$];
  int unsigned          fail_cnt;
  // Number of long receiver holds requested so far
  int unsigned          hold_req;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Expected compaction: in-use nonzeros in order, zeros above, plus their count
  function automatic compaction_t compact_row(input row_t row, input logic [ROW_LEN_W-1:0] len);
    compaction_t res;
    int unsigned used;
    int unsigned slot;
    res  = '0;
    slot = 0;
    used = (len > LANES) ? LANES : len;
    for (int i = 0; i < used; i++) begin
      if (row.lanes[i] != '0) begin
        res.slots[slot] = row.lanes[i];
        slot++;
      end
    end
    res.count = CNT_W'(slot);
    res.last  = row.last;
    return res;
  endfunction

  function automatic void flag_error(input string what);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) begin
      $display("%0t: error: %s", $realtime, what);
    end
  endfunction

  function automatic elem_t rand_nz();
    elem_t v;
    do v = elem_t'($urandom); while (v == '0);
    return v;
  endfunction

  // Zero with the given percentage, else mostly random with some extremes
  function automatic elem_t rand_elem(input int unsigned zero_pct);
    if ($urandom_range(99) < zero_pct) return '0;
    case ($urandom_range(11))
      0: return elem_t'(16'h8000);
      1: return elem_t'(16'h7FFF);
      2: return elem_t'(16'h0001);
      3: return elem_t'(16'hFFFF);
      default: return rand_nz();
    endcase
  endfunction

  function automatic row_t rand_row(input int unsigned zero_pct);
    row_t row;
    for (int i = 0; i < LANES; i++) row.lanes[i] = rand_elem(zero_pct);
    row.last = ($urandom_range(7) == 0);
    return row;
  endfunction

  // Lane i is a random nonzero where mask bit i is set, else zero
  function automatic row_t pattern_row(input logic [LANES-1:0] nz_mask, input logic last);
    row_t row;
    for (int i = 0; i < LANES; i++) row.lanes[i] = nz_mask[i] ? rand_nz() : elem_t'(0);
    row.last = last;
    return row;
  endfunction

  function automatic row_t uniform_row(input elem_t v, input logic last);
    row_t row;
    row.lanes = {LANES{v}};
    row.last  = last;
    return row;
  endfunction

  // Offer one row and hold it until the transaction completes
  task automatic send_row(input row_t row);
    @(negedge clk_i);
    row_ch.valid    = 1'b1;
    row_ch.lane_0   = row.lanes[0];
    row_ch.lane_1   = row.lanes[1];
    row_ch.lane_2   = row.lanes[2];
    row_ch.lane_3   = row.lanes[3];
    row_ch.lane_4   = row.lanes[4];
    row_ch.lane_5   = row.lanes[5];
    row_ch.lane_6   = row.lanes[6];
    row_ch.lane_7   = row.lanes[7];
    row_ch.row_last = row.last;
    do @(posedge clk_i); while (!row_ch.ready);
    pending_compactions.insert(pending_compactions.size(), compact_row(row, cur_row_len));
  endtask

  task automatic pause_rows(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk_i);
      row_ch.valid = 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // Stop sending, wait for every result, then let the pipeline go quiet
  task automatic settle_pipeline();
    pause_rows(1);
    while (pending_compactions.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((addr >> 2) == REG_ROW_LENGTH) cur_row_len = data[ROW_LEN_W-1:0];
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Read row_length back and compare with the shadow copy
  task automatic check_row_length();
    logic [APB_DATA_W-1:0] data;
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = ADDR_ROW_LENGTH;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    if (data[ROW_LEN_W-1:0] !== cur_row_len) begin
      flag_error($sformatf("row_length read expected %0d got %0d", cur_row_len,
                           data[ROW_LEN_W-1:0]));
    end
  endtask

  // Upper data bits are random; only the low nibble is kept
  task automatic set_row_length(input logic [ROW_LEN_W-1:0] len);
    logic [APB_DATA_W-1:0] data;
    data                = $urandom;
    data[ROW_LEN_W-1:0] = len;
    settle_pipeline();
    apb_write(ADDR_ROW_LENGTH, data);
  endtask

  // Reset value, readback, a write outside the register map, two rows and length writes
  task automatic test_reset_and_regs();
    check_row_length();
    apb_write(ADDR_UNMAPPED, $urandom);
    check_row_length();
    send_row(pattern_row(8'hFF, 1'b0));
    send_row(pattern_row(8'h81, 1'b1));
    set_row_length(4'd15);
    check_row_length();
    set_row_length(4'd8);
    check_row_length();
  endtask

  // Field extremes, shift patterns and the row length corner values
  task automatic test_directed_rows();
    send_row(uniform_row(elem_t'(16'h0000), 1'b0));
    send_row(uniform_row(elem_t'(16'h7FFF), 1'b0));
    send_row(uniform_row(elem_t'(16'h8000), 1'b1));
    send_row(uniform_row(elem_t'(16'hFFFF), 1'b0));
    send_row(uniform_row(elem_t'(16'h0001), 1'b1));
    send_row(pattern_row(8'hAA, 1'b0));
    send_row(pattern_row(8'h55, 1'b0));
    send_row(pattern_row(8'hF0, 1'b0));
    // single nonzero at the top lane takes the longest shift
    send_row(pattern_row(8'h80, 1'b1));
    send_row(pattern_row(8'h01, 1'b0));
    send_row(pattern_row(8'hFE, 1'b0));
    send_row(pattern_row(8'h7F, 1'b0));
    send_row(pattern_row(8'h0F, 1'b1));
    // no lane in use
    set_row_length(4'd0);
    send_row(pattern_row(8'hFF, 1'b0));
    // one lane in use; the nonzeros above it must not leak
    set_row_length(4'd1);
    send_row(pattern_row(8'hFE, 1'b0));
    send_row(pattern_row(8'h01, 1'b1));
    set_row_length(4'd3);
    send_row(pattern_row(8'hFA, 1'b0));
    // lengths above eight behave as eight
    set_row_length(4'd9);
    send_row(pattern_row(8'h5A, 1'b0));
    set_row_length(4'd15);
    send_row(pattern_row(8'hFF, 1'b1));
    set_row_length(4'd8);
  endtask

  // Every register value with a few rows each
  task automatic test_length_sweep();
    for (int len = 0; len < (1 << ROW_LEN_W); len++) begin
      set_row_length(ROW_LEN_W'(len));
      repeat (4) send_row(rand_row(40));
    end
  endtask

  // Receiver holds off while rows keep coming, so the pipeline fills and stalls
  task automatic test_output_backpressure();
    set_row_length(4'd8);
    hold_req++;
    repeat (40) send_row(rand_row(30));
    settle_pipeline();
  endtask

  // Random rows in bursts, with a new length and sparsity per phase
  task automatic test_random_rows();
    int unsigned n_rows;
    int unsigned sent;
    int unsigned burst;
    int unsigned zero_pct;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      set_row_length(($urandom_range(3) == 0) ? 4'd8 : ROW_LEN_W'($urandom_range(15)));
      zero_pct = 25 * $urandom_range(4);
      n_rows   = $urandom_range(80, 120);
      sent     = 0;
      while (sent < n_rows) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst && sent < n_rows; b++) begin
          send_row(rand_row(zero_pct));
          sent++;
        end
        pause_rows(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10));
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    row_ch.valid     = 1'b0;
    row_ch.lane_0    = '0;
    row_ch.lane_1    = '0;
    row_ch.lane_2    = '0;
    row_ch.lane_3    = '0;
    row_ch.lane_4    = '0;
    row_ch.lane_5    = '0;
    row_ch.lane_6    = '0;
    row_ch.lane_7    = '0;
    row_ch.row_last  = 1'b0;
    hold_req         = 0;
    fail_cnt         = 0;
    cur_row_len      = ROW_LEN_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_and_regs();
    test_directed_rows();
    test_length_sweep();
    test_output_backpressure();
    test_random_rows();
    settle_pipeline();

    if (pending_compactions.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_compactions.size()));
    end
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver pacing; a new hold request forces a long stall counted here
  initial begin : sink_pacer
    pace_e       mode;
    int unsigned span;
    int unsigned holds_seen;
    holds_seen    = 0;
    pack_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      mode = pace_e'($urandom_range(2));
      span = $urandom_range(5, 60);
      for (int k = 0; k < span; k++) begin
        @(negedge clk_i);
        if (hold_req != holds_seen) begin
          pack_ch.ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
          holds_seen = hold_req;
        end
        case (mode)
          PACE_FREE:   pack_ch.ready = 1'b1;
          PACE_RANDOM: pack_ch.ready = ($urandom_range(3) != 0);
          default:     pack_ch.ready = ((k % 5) < 3);
        endcase
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : check_results
    compaction_t got;
    compaction_t want;
    if (rst_ni && pack_ch.valid && pack_ch.ready) begin
      got.slots[0] = pack_ch.packed_0;
      got.slots[1] = pack_ch.packed_1;
      got.slots[2] = pack_ch.packed_2;
      got.slots[3] = pack_ch.packed_3;
      got.slots[4] = pack_ch.packed_4;
      got.slots[5] = pack_ch.packed_5;
      got.slots[6] = pack_ch.packed_6;
      got.slots[7] = pack_ch.packed_7;
      got.count    = pack_ch.nonzero_count;
      got.last     = pack_ch.last_row_out;
      if (pending_compactions.size() == 0) begin
        flag_error($sformatf("unexpected result %h", got));
      end else begin
        want = pending_compactions.pop_front();
        for (int k = 0; k < LANES; k++) begin
          if (got.slots[k] !== want.slots[k]) begin
            flag_error($sformatf("packed_%0d expected %h got %h", k, want.slots[k],
                                 got.slots[k]));
          end
        end
        if (got.count !== want.count) begin
          flag_error($sformatf("nonzero_count expected %0d got %0d", want.count, got.count));
        end
        if (got.last !== want.last) begin
          flag_error($sformatf("last_row_out expected %b got %b", want.last, got.last));
        end
      end
    end
  end

  // Watchdog: too many cycles without any transaction ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (row_ch.valid && row_ch.ready) || (pack_ch.valid && pack_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $realtime,
                 pending_compactions.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rze_pkg.sv
rtl/core/rze_row_if.sv
rtl/core/rze_pack_if.sv
rtl/core/rze_shift_stage.sv
rtl/core/row_zero_elimination_unit.sv
test/testbench.sv
